// File: hw/rtl/alamouti_stbc_framer_unit_defines.svh
// Assertion macros for the framer top file, which checks its own logic.
`ifndef ALAMOUTI_STBC_FRAMER_UNIT_DEFINES_SVH
`define ALAMOUTI_STBC_FRAMER_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define ASF_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define ASF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define ASF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/asf_pkg.sv
package asf_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int GOLD_LENGTH  = 64;
  localparam int PILOT_PERIOD = 4;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_PAYLOAD_PAIRS        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PILOT_SLOTS          = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PREAMBLE_SLOTS       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PACKETS_PER_PREAMBLE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PREAMBLE_ONCE        = 3'd4;

  // Slot kinds, also used as the framer phase codes.
  localparam logic [1:0] KIND_PREAMBLE = 2'd0;
  localparam logic [1:0] KIND_PILOT0   = 2'd1;
  localparam logic [1:0] KIND_PILOT1   = 2'd2;
  localparam logic [1:0] KIND_DATA     = 2'd3;

  // Gold sequence, entry 0 first.
  localparam logic [0:63] GOLD_SEQ =
    64'b1001100001000000001_1101000111110100111_0000110111111001001_1101111;

  // QPSK pilot points: bit 1 real part positive, bit 0 imaginary part positive.
  localparam logic [1:0] PILOT_TAB [4] = '{2'b10, 2'b01, 2'b11, 2'b00};

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  localparam sample_t S_ONE  = sample_t'(1 << (SAMPLE_WIDTH - 2));
  localparam sample_t S_MONE = sample_t'(-(1 << (SAMPLE_WIDTH - 2)));
  localparam sample_t S_MAX  = sample_t'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam sample_t S_MIN  = sample_t'(-(1 << (SAMPLE_WIDTH - 1)));

  typedef struct packed {
    sample_t first_re;
    sample_t first_im;
    sample_t second_re;
    sample_t second_im;
  } asf_pair_t;

  typedef struct packed {
    sample_t    ant0_re;
    sample_t    ant0_im;
    sample_t    ant1_re;
    sample_t    ant1_im;
    logic       pair_taken;
    logic [1:0] slot_kind;
    logic       last;
  } asf_slot_t;

  // One classified item waiting for the back end.
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] code;
    asf_pair_t  pair;
  } asf_entry_t;

  typedef struct packed {
    logic              full;
    logic              head_valid;
    logic [QCNT_W-1:0] count;
  } asf_qstat_t;

  function automatic sample_t sat_neg(sample_t v);
    sample_t r;
    r = -v;
    if (v == S_MIN) begin
      r = S_MAX;
    end
    return r;
  endfunction

  function automatic sample_t unit_of(logic pos);
    return pos ? S_ONE : S_MONE;
  endfunction

endpackage

// File: hw/rtl/asf_front.sv
module asf_front #(
  parameter int GOLD_LENGTH  = asf_pkg::GOLD_LENGTH,
  parameter int PILOT_PERIOD = asf_pkg::PILOT_PERIOD
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [asf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [asf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               push,
  input  asf_pkg::asf_pair_t                 pair,
  input  logic                               q_full,
  output logic                               q_push,
  output asf_pkg::asf_entry_t                q_entry
);

  localparam logic [6:0] GOLD_LIM  = 7'(GOLD_LENGTH);
  localparam logic [1:0] PPOS_LAST = 2'(PILOT_PERIOD - 1);

  logic [15:0] payload_pairs;
  logic [12:0] pilot_slots;
  logic [6:0]  preamble_slots;
  logic [15:0] packets_per_preamble;
  logic        preamble_once;

  logic [1:0]  phase, phase_next;
  logic [6:0]  preamble_count, preamble_count_next;
  logic [12:0] pilot_count, pilot_count_next;
  logic [1:0]  pilot_pos, pilot_pos_next;
  logic [15:0] pair_count, pair_count_next;
  logic [15:0] packet_count, packet_count_next;

  logic [6:0]  pre_lim;
  logic [6:0]  pre_inc;
  logic [12:0] pil_lim, pil_inc;
  logic [15:0] pay_lim, pay_inc, pkt_lim, pkt_inc;
  logic        gold_bit;

  assign q_push = push && !q_full;

  always_comb begin
    pre_lim = (preamble_slots == 7'd0) ? 7'd1 : preamble_slots;
    if (pre_lim > GOLD_LIM) begin
      pre_lim = GOLD_LIM;
    end
    pil_lim  = (pilot_slots == 13'd0) ? 13'd1 : pilot_slots;
    pay_lim  = (payload_pairs == 16'd0) ? 16'd1 : payload_pairs;
    pkt_lim  = (packets_per_preamble == 16'd0) ? 16'd1 : packets_per_preamble;
    pre_inc  = preamble_count + 7'd1;
    pil_inc  = pilot_count + 13'd1;
    pay_inc  = pair_count + 16'd1;
    pkt_inc  = packet_count + 16'd1;
    gold_bit = asf_pkg::GOLD_SEQ[preamble_count[5:0]];

    phase_next          = phase;
    preamble_count_next = preamble_count;
    pilot_count_next    = pilot_count;
    pilot_pos_next      = pilot_pos;
    pair_count_next     = pair_count;
    packet_count_next   = packet_count;

    q_entry.kind = phase;
    q_entry.pair = pair;
    q_entry.code = asf_pkg::PILOT_TAB[pilot_pos];

    case (phase)
      asf_pkg::KIND_PREAMBLE: begin
        q_entry.code        = {gold_bit, gold_bit};
        preamble_count_next = pre_inc;
        if (pre_inc >= pre_lim) begin
          preamble_count_next = 7'd0;
          phase_next          = asf_pkg::KIND_PILOT0;
        end
      end
      asf_pkg::KIND_PILOT0, asf_pkg::KIND_PILOT1: begin
        pilot_count_next = pil_inc;
        pilot_pos_next   = (pilot_pos >= PPOS_LAST) ? 2'd0 : pilot_pos + 2'd1;
        if (pil_inc >= pil_lim) begin
          pilot_count_next = 13'd0;
          pilot_pos_next   = 2'd0;
          phase_next       = (phase == asf_pkg::KIND_PILOT0) ? asf_pkg::KIND_PILOT1
                                                              : asf_pkg::KIND_DATA;
        end
      end
      default: begin
        pair_count_next = pay_inc;
        if (pay_inc >= pay_lim) begin
          pair_count_next   = 16'd0;
          phase_next        = asf_pkg::KIND_PILOT0;
          packet_count_next = pkt_inc;
          if (pkt_inc >= pkt_lim) begin
            packet_count_next = 16'd0;
            if (!preamble_once) begin
              phase_next = asf_pkg::KIND_PREAMBLE;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_pairs        <= 16'd1024;
      pilot_slots          <= 13'd128;
      preamble_slots       <= 7'd64;
      packets_per_preamble <= 16'd32;
      preamble_once        <= 1'b0;
      phase                <= asf_pkg::KIND_PREAMBLE;
      preamble_count       <= 7'd0;
      pilot_count          <= 13'd0;
      pilot_pos            <= 2'd0;
      pair_count           <= 16'd0;
      packet_count         <= 16'd0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          asf_pkg::CFG_PAYLOAD_PAIRS:        payload_pairs        <= cfg_data;
          asf_pkg::CFG_PILOT_SLOTS:          pilot_slots          <= cfg_data[12:0];
          asf_pkg::CFG_PREAMBLE_SLOTS:       preamble_slots       <= cfg_data[6:0];
          asf_pkg::CFG_PACKETS_PER_PREAMBLE: packets_per_preamble <= cfg_data;
          asf_pkg::CFG_PREAMBLE_ONCE:        preamble_once        <= cfg_data[0];
          default: ;
        endcase
      end
      if (q_push) begin
        phase          <= phase_next;
        preamble_count <= preamble_count_next;
        pilot_count    <= pilot_count_next;
        pilot_pos      <= pilot_pos_next;
        pair_count     <= pair_count_next;
        packet_count   <= packet_count_next;
      end
    end
  end

endmodule

// File: hw/rtl/asf_queue.sv
module asf_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  asf_pkg::asf_entry_t wr_entry,
  input  logic                rd_en,
  output asf_pkg::asf_entry_t rd_entry,
  output asf_pkg::asf_qstat_t stat
);

  localparam int DEPTH = asf_pkg::QUEUE_DEPTH;
  localparam logic [asf_pkg::QPTR_W-1:0] PTR_LAST = asf_pkg::QPTR_W'(DEPTH - 1);
  localparam logic [asf_pkg::QCNT_W-1:0] CNT_FULL = asf_pkg::QCNT_W'(DEPTH);

  asf_pkg::asf_entry_t            store [DEPTH];
  logic [asf_pkg::QPTR_W-1:0]     wptr, rptr;
  logic [asf_pkg::QCNT_W-1:0]     count;

  assign rd_entry        = store[rptr];
  assign stat.count      = count;
  assign stat.full       = (count == CNT_FULL);
  assign stat.head_valid = (count != '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= (wptr == PTR_LAST) ? '0 : wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= (rptr == PTR_LAST) ? '0 : rptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/asf_back.sv
module asf_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  asf_pkg::asf_entry_t head,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output asf_pkg::asf_slot_t  slot
);

  logic               out_valid;
  logic               half;
  logic               load;
  logic               is_data;
  asf_pkg::asf_slot_t slot_next;

  assign empty   = !out_valid;
  assign load    = head_valid && (!out_valid || pop);
  assign is_data = (head.kind == asf_pkg::KIND_DATA);
  // A data pair stays at the head until its second slot is built.
  assign q_pop   = load && !(is_data && !half);

  always_comb begin
    slot_next.slot_kind  = head.kind;
    slot_next.pair_taken = 1'b0;
    slot_next.last       = 1'b1;
    slot_next.ant0_re    = asf_pkg::unit_of(head.code[1]);
    slot_next.ant0_im    = asf_pkg::unit_of(head.code[0]);
    slot_next.ant1_re    = '0;
    slot_next.ant1_im    = '0;
    case (head.kind)
      asf_pkg::KIND_PREAMBLE: begin
        slot_next.ant0_im = asf_pkg::unit_of(head.code[1]);
        slot_next.ant1_re = asf_pkg::unit_of(head.code[1]);
        slot_next.ant1_im = asf_pkg::unit_of(head.code[1]);
      end
      asf_pkg::KIND_PILOT0: ;
      asf_pkg::KIND_PILOT1: begin
        slot_next.ant0_re = '0;
        slot_next.ant0_im = '0;
        slot_next.ant1_re = asf_pkg::unit_of(head.code[1]);
        slot_next.ant1_im = asf_pkg::unit_of(head.code[0]);
      end
      default: begin
        slot_next.pair_taken = 1'b1;
        slot_next.last       = half;
        if (!half) begin
          slot_next.ant0_re = head.pair.first_re;
          slot_next.ant0_im = head.pair.first_im;
          slot_next.ant1_re = head.pair.second_re;
          slot_next.ant1_im = head.pair.second_im;
        end else begin
          slot_next.ant0_re = asf_pkg::sat_neg(head.pair.second_re);
          slot_next.ant0_im = head.pair.second_im;
          slot_next.ant1_re = head.pair.first_re;
          slot_next.ant1_im = asf_pkg::sat_neg(head.pair.first_im);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= slot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      half      <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        half      <= is_data && !half;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/alamouti_stbc_framer_unit.sv
// Each item transferred in is written into the queue; the back end registers its slot
// from the queue head. Throughput: one slot per cycle while popped, so preamble and pilot
// items give one slot each and a data pair gives two; the four-entry queue absorbs bursts.
// Reset: synchronous, active high; it loads the register defaults, restarts in the
// preamble phase with all counters at zero and empties the queue and output register.
`include "alamouti_stbc_framer_unit_defines.svh"

module alamouti_stbc_framer_unit #(
  parameter int GOLD_LENGTH  = asf_pkg::GOLD_LENGTH,
  parameter int PILOT_PERIOD = asf_pkg::PILOT_PERIOD
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [asf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [asf_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Input side: one offered symbol pair per transfer.
  input  logic                            push,
  output logic                            full,
  input  asf_pkg::asf_pair_t              pair,
  // Result side: one antenna slot per transfer.
  output logic                            empty,
  input  logic                            pop,
  output asf_pkg::asf_slot_t              slot
);

  // The front end runs the phase counters and classifies each item as it is
  // transferred in; the back end expands each entry into one or two slots.
  logic                q_push;
  logic                q_pop;
  asf_pkg::asf_entry_t q_wr_entry;
  asf_pkg::asf_entry_t q_head;
  asf_pkg::asf_qstat_t q_stat;

  // Registers are plain flops and can be written in any cycle.
  assign cfg_ready = 1'b1;
  assign full      = q_stat.full;

  asf_front #(
    .GOLD_LENGTH  (GOLD_LENGTH),
    .PILOT_PERIOD (PILOT_PERIOD)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .pair      (pair),
    .q_full    (q_stat.full),
    .q_push    (q_push),
    .q_entry   (q_wr_entry)
  );

  asf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_entry (q_wr_entry),
    .rd_en    (q_pop),
    .rd_entry (q_head),
    .stat     (q_stat)
  );

  asf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_stat.head_valid),
    .head       (q_head),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .slot       (slot)
  );

  // The queue never holds more entries than it has room for.
  `ASF_ASSERT_ALWAYS(a_queue_bound, q_stat.count <= asf_pkg::QCNT_W'(asf_pkg::QUEUE_DEPTH), "queue overrun")
  // The first slot of a data pair is always followed by its second slot.
  `ASF_ASSERT_NEXT(a_pair_second, !empty && !slot.last, !empty, "second data slot lost")
  // Only data slots consume the pair.
  `ASF_ASSERT_SAME(a_taken_kind, !empty, slot.pair_taken == (slot.slot_kind == asf_pkg::KIND_DATA), "pair_taken mismatch")
  // Preamble and pilot slots are single results.
  `ASF_ASSERT_SAME(a_single_last, !empty && slot.slot_kind != asf_pkg::KIND_DATA, slot.last, "single slot without last")

endmodule
